FILE: rtl/assert_macros.svh
// Assertion macros used by the padder top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_ON(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/smp_pkg.sv
// Shared types, constants and helpers for the SHA-2 message padder.
`timescale 1ns / 1ps

package smp_pkg;

  localparam logic [7:0] PadMark  = 8'h80;
  localparam logic [6:0] Mask256  = 7'h3F;
  localparam logic [6:0] Mask384  = 7'h7F;
  localparam logic [6:0] Room256  = 7'd56;
  localparam logic [6:0] Room384  = 7'd112;
  localparam logic       OpAppend = 1'b0;
  localparam logic       OpFinish = 1'b1;

  // Padding sequencer status and current word, seen by the top level
  typedef struct packed {
    logic        busy;
    logic [63:0] word;
    logic        block_end;
    logic        message_end;
  } pad_out_t;

  // Block position mask for the selected mode
  function automatic logic [6:0] pos_mask(input logic mode);
    pos_mask = mode ? Mask384 : Mask256;
  endfunction

  // Closing word of a block: word index sits on the last slot of the block
  function automatic logic blk_close(input logic [3:0] widx, input logic mode);
    logic [6:0] mask_full;
    logic [3:0] m;
    mask_full = pos_mask(mode);
    m         = mask_full[6:3];
    blk_close = (widx & m) == m;
  endfunction

  // First padding word: tail bytes at the top, then the marker, then zeros
  function automatic logic [63:0] first_word(input logic [55:0] partial,
                                             input logic [2:0]  wpos);
    logic [5:0] sh;
    sh = {3'd7 - wpos, 3'b000};
    first_word = {partial, PadMark} << sh;
  endfunction

endpackage

FILE: rtl/smp_accum.sv
// Byte counter and partial word buffer of the current message.
`timescale 1ns / 1ps

module smp_accum (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  logic [7:0]  byte_i,
  input  logic        clear_i,
  output logic [63:0] byte_count_o,
  output logic [55:0] partial_o
);

  logic [63:0] byte_count_q, byte_count_d;
  logic [55:0] partial_q, partial_d;

  // Clear on request; else advance the count and shift in a byte, dropping the buffer on a full word
  always_comb begin
    byte_count_d = byte_count_q;
    partial_d    = partial_q;
    if (clear_i) begin
      byte_count_d = '0;
      partial_d    = '0;
    end else if (push_i) begin
      byte_count_d = byte_count_q + 64'd1;
      if (byte_count_q[2:0] == 3'd7) begin
        partial_d = '0;
      end else begin
        partial_d = {partial_q[47:0], byte_i};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q <= '0;
      partial_q    <= '0;
    end else begin
      byte_count_q <= byte_count_d;
      partial_q    <= partial_d;
    end
  end

  assign byte_count_o = byte_count_q;
  assign partial_o    = partial_q;

endmodule

FILE: rtl/smp_pad_seq.sv
// Padding sequencer: walks the tail, zero fill and length words of a message.
`timescale 1ns / 1ps

module smp_pad_seq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             mode_i,
  input  logic             start_i,
  input  logic             advance_i,
  input  logic [63:0]      byte_count_i,
  input  logic [55:0]      partial_i,
  output smp_pkg::pad_out_t pad_o
);

  logic       busy_q, busy_d;
  logic [4:0] widx_q, widx_d;
  logic [3:0] first_q, first_d;
  logic [4:0] last_q, last_d;
  logic [6:0] pos;
  logic       room_ok;
  logic       is_last;

  // Block position and whether the length still fits in this block
  assign pos     = byte_count_i[6:0] & smp_pkg::pos_mask(mode_i);
  assign room_ok = pos < (mode_i ? smp_pkg::Room384 : smp_pkg::Room256);
  assign is_last = widx_q == last_q;

  // Load the word range on a finish beat, step one word per emitted beat
  always_comb begin
    busy_d  = busy_q;
    widx_d  = widx_q;
    first_d = first_q;
    last_d  = last_q;
    if (start_i) begin
      busy_d  = 1'b1;
      widx_d  = {1'b0, pos[6:3]};
      first_d = pos[6:3];
      unique case ({mode_i, room_ok})
        2'b01:   last_d = 5'd7;
        2'b00:   last_d = 5'd15;
        2'b11:   last_d = 5'd15;
        default: last_d = 5'd31;
      endcase
    end else if (advance_i) begin
      widx_d = widx_q + 5'd1;
      if (is_last) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      widx_q  <= '0;
      first_q <= '0;
      last_q  <= '0;
    end else begin
      busy_q  <= busy_d;
      widx_q  <= widx_d;
      first_q <= first_d;
      last_q  <= last_d;
    end
  end

  // Select length, marker word or zero fill for the current index
  always_comb begin
    pad_o.busy        = busy_q;
    pad_o.message_end = is_last;
    pad_o.block_end   = smp_pkg::blk_close(widx_q[3:0], mode_i);
    if (is_last) begin
      pad_o.word = {byte_count_i[60:0], 3'b000};
    end else if (widx_q == {1'b0, first_q}) begin
      pad_o.word = smp_pkg::first_word(partial_i, byte_count_i[2:0]);
    end else begin
      pad_o.word = '0;
    end
  end

endmodule

FILE: rtl/sha2_message_padder.sv
// Append: a word leaves in the cycle after its eighth byte; one byte accepted per cycle
// while the input is not stalled. Finish: the finish beat loads the sequencer, then one
// padded word per cycle while the output is not stalled (2 to 18 words); the input
// stalls until the last word of the message is in the output register.
// Reset clears the count, the partial word, the sequencer and the mode (SHA-256).
`timescale 1ns / 1ps

`include "assert_macros.svh"

module sha2_message_padder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        opcode_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] word_o,
  output logic        block_end_o,
  output logic        message_end_o
);

  logic              mode_q;
  logic              out_valid_q, out_valid_d;
  logic [63:0]       word_q, word_d;
  logic              block_end_q, block_end_d;
  logic              message_end_q, message_end_d;
  logic              slot_free;
  logic              in_acc;
  logic              push, start, advance, done;
  logic [63:0]       byte_count;
  logic [55:0]       partial;
  logic [6:0]        mask;
  smp_pkg::pad_out_t pad;

  // Mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
    end
  end

  // Input handshake
  assign slot_free  = !out_valid_q || !out_stall_i;
  assign in_stall_o = pad.busy || !slot_free;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign push       = in_acc && (opcode_i == smp_pkg::OpAppend);
  assign start      = in_acc && (opcode_i == smp_pkg::OpFinish);
  assign advance    = pad.busy && slot_free;
  assign done       = advance && pad.message_end;
  assign mask       = smp_pkg::pos_mask(mode_q);

  smp_accum u_accum (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .byte_i       (data_byte_i),
    .clear_i      (done),
    .byte_count_o (byte_count),
    .partial_o    (partial)
  );

  smp_pad_seq u_pad_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .mode_i       (mode_q),
    .start_i      (start),
    .advance_i    (advance),
    .byte_count_i (byte_count),
    .partial_i    (partial),
    .pad_o        (pad)
  );

  // Load the output register from the append path or the padding run
  always_comb begin
    out_valid_d   = out_valid_q && out_stall_i;
    word_d        = word_q;
    block_end_d   = block_end_q;
    message_end_d = message_end_q;
    if (advance) begin
      out_valid_d   = 1'b1;
      word_d        = pad.word;
      block_end_d   = pad.block_end;
      message_end_d = pad.message_end;
    end else if (push && byte_count[2:0] == 3'd7) begin
      out_valid_d   = 1'b1;
      word_d        = {partial, data_byte_i};
      block_end_d   = (byte_count[6:0] & mask) == mask;
      message_end_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q        <= word_d;
    block_end_q   <= block_end_d;
    message_end_q <= message_end_d;
  end

  assign out_valid_o   = out_valid_q;
  assign word_o        = word_q;
  assign block_end_o   = block_end_q;
  assign message_end_o = message_end_q;

  // Checks
  `ASSERT_ON(a_finish_starts_run, clk_i, rst_ni, start |=> pad.busy, "finish did not start padding")
  `ASSERT_ON(a_end_closes_block, clk_i, rst_ni, out_valid_o && message_end_o |-> block_end_o, "message end off a block boundary")
  `ASSERT_ON(a_done_clears_count, clk_i, rst_ni, done |=> byte_count == 64'd0 && !pad.busy, "count not cleared after padding")
  `ASSERT_ALWAYS(a_reset_no_valid, clk_i, !rst_ni |-> !out_valid_o, "output valid during reset")

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the SHA-2 message padder with random beat gaps and stalls.
`timescale 1ns / 1ps

module tb;

  localparam logic ModeSha256   = 1'b0;
  localparam logic ModeSha384   = 1'b1;
  localparam int   ItemTarget   = 460;
  localparam int   SettleCycles = 8;

  typedef struct packed {
    logic [63:0] word;
    logic        block_end;
    logic        message_end;
  } padded_word_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_wdata_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic        opcode_i;
  logic [7:0]  data_byte_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [63:0] word_o;
  logic        block_end_o;
  logic        message_end_o;

  // Expected output beats, oldest first
  padded_word_t pending_words[$];
  int mismatch_count;
  int items_sent;
  bit in_gaps_on;
  bit out_gaps_on;
  int hold_request;
  int hold_left;
  int stall_left;

  // Predicted padder state
  logic [63:0] msg_len;
  logic [55:0] tail_bytes;
  logic        mode_384;

  sha2_message_padder u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .opcode_i     (opcode_i),
    .data_byte_i  (data_byte_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .word_o       (word_o),
    .block_end_o  (block_end_o),
    .message_end_o(message_end_o)
  );

  // Clock: 10 ns period
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Bail out if the run hangs
  initial begin
    #5_000_000;
    $display("tb NOT OK");
    $finish;
  end

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Work out the words that one accepted item produces and queue them
  function automatic void predict_padding(input logic op, input logic [7:0] b);
    int           mask_i;
    int           room_i;
    int           pos;
    int           wpos;
    int           first;
    int           last;
    logic [63:0]  w;
    padded_word_t pw;
    mask_i = (mode_384 == ModeSha384) ? int'(smp_pkg::Mask384) : int'(smp_pkg::Mask256);
    room_i = (mode_384 == ModeSha384) ? int'(smp_pkg::Room384) : int'(smp_pkg::Room256);
    pos    = int'(msg_len[6:0]) & mask_i;
    if (op == smp_pkg::OpAppend) begin
      w = {tail_bytes, b};
      msg_len = msg_len + 64'd1;
      if ((pos & 7) == 7) begin
        pw.word        = w;
        pw.block_end   = ((pos + 1) & mask_i) == 0;
        pw.message_end = 1'b0;
        pending_words.push_back(pw);
        tail_bytes = '0;
      end else begin
        tail_bytes = w[55:0];
      end
    end else begin
      wpos  = pos & 7;
      first = pos >> 3;
      last  = ((pos < room_i) ? (mask_i + 1) : 2 * (mask_i + 1)) / 8 - 1;
      for (int wi = first; wi <= last; wi++) begin
        w = '0;
        if (wi == first) begin
          if (wpos != 0) w = {8'h00, tail_bytes} << (64 - 8 * wpos);
          w = w | ({56'd0, smp_pkg::PadMark} << (56 - 8 * wpos));
        end
        // Length field overrides the last word
        if (wi == last) w = msg_len << 3;
        pw.word        = w;
        pw.block_end   = (((wi + 1) * 8) & mask_i) == 0;
        pw.message_end = (wi == last);
        pending_words.push_back(pw);
      end
      msg_len    = '0;
      tail_bytes = '0;
    end
  endfunction

  // Offer one beat, hold it until accepted, then maybe idle
  task automatic offer_item(input logic op, input logic [7:0] b);
    int gap;
    in_valid_i  <= 1'b1;
    opcode_i    <= op;
    data_byte_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    predict_padding(op, b);
    items_sent++;
    gap = in_gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic finish_message();
    offer_item(smp_pkg::OpFinish, 8'($urandom_range(0, 255)));
  endtask

  // Drop valid and wait until every expected word has come out
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_hash_mode(input logic m);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    mode_384 = m;
  endtask

  // Receiver: check each output beat, then choose the stall for the next cycle
  always @(posedge clk_i) begin : rx_check
    padded_word_t exp_w;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_words.size() == 0) begin
          $error("unexpected word %h", word_o);
          mismatch_count++;
        end else begin
          exp_w = pending_words.pop_front();
          if (word_o !== exp_w.word) begin
            $error("word: expected %h, got %h", exp_w.word, word_o);
            mismatch_count++;
          end
          if (block_end_o !== exp_w.block_end) begin
            $error("block_end: expected %b, got %b", exp_w.block_end, block_end_o);
            mismatch_count++;
          end
          if (message_end_o !== exp_w.message_end) begin
            $error("message_end: expected %b, got %b", exp_w.message_end, message_end_o);
            mismatch_count++;
          end
        end
      end
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
        if (out_gaps_on) stall_left = pick_gap();
      end
    end
  end

  // Empty messages in both modes: marker, zero fill, zero length
  task automatic test_empty_messages();
    set_hash_mode(ModeSha256);
    finish_message();
    set_hash_mode(ModeSha384);
    finish_message();
  endtask

  // Byte extremes, one full word, then a short tail
  task automatic test_word_packing();
    logic [7:0] bytes[11] = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h7F, 8'hFE, 8'h55, 8'hAA,
                              8'hFF, 8'h00, 8'hFF};
    set_hash_mode(ModeSha256);
    foreach (bytes[i]) offer_item(smp_pkg::OpAppend, bytes[i]);
    finish_message();
  endtask

  // Switch block size while a message is half written
  task automatic test_mode_switch_mid_message();
    set_hash_mode(ModeSha256);
    repeat (5) offer_item(smp_pkg::OpAppend, 8'($urandom_range(0, 255)));
    set_hash_mode(ModeSha384);
    repeat (6) offer_item(smp_pkg::OpAppend, 8'($urandom_range(0, 255)));
    finish_message();
  endtask

  // Receiver holds off while the sender keeps pushing, so the input backs up
  task automatic test_backpressure();
    in_gaps_on  = 1'b0;
    out_gaps_on = 1'b0;
    set_hash_mode(1'($urandom_range(0, 1)));
    hold_request = 200;
    repeat (40) offer_item(smp_pkg::OpAppend, 8'($urandom_range(0, 255)));
    finish_message();
    offer_item(smp_pkg::OpAppend, 8'($urandom_range(0, 255)));
    finish_message();
    wait_drained();
  endtask

  // Message length, biased toward the padding and block boundaries
  function automatic int pick_msg_len();
    int base;
    int r;
    int edges[7];
    base  = (mode_384 == ModeSha384) ? 128 : 64;
    edges = '{base - 9, base - 8, base - 7, base - 1, base, base + 1, 2 * base - 8};
    r = $urandom_range(0, 99);
    if (r < 55) return $urandom_range(0, 20);
    if (r < 85) return edges[$urandom_range(0, 6)];
    return $urandom_range(21, 140);
  endfunction

  // Random well-formed messages, some mode changes, some loose noise
  task automatic test_random_messages();
    int len;
    int split;
    while (items_sent < ItemTarget) begin
      in_gaps_on  = ($urandom_range(0, 3) != 0);
      out_gaps_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) < 3) set_hash_mode(1'($urandom_range(0, 1)));
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 10))
          offer_item(($urandom_range(0, 3) == 0) ? smp_pkg::OpFinish : smp_pkg::OpAppend,
                     8'($urandom_range(0, 255)));
      end else begin
        len   = pick_msg_len();
        split = ($urandom_range(0, 9) == 0) ? $urandom_range(0, len) : -1;
        for (int i = 0; i < len; i++) begin
          if (i == split) set_hash_mode(1'($urandom_range(0, 1)));
          offer_item(smp_pkg::OpAppend, 8'($urandom_range(0, 255)));
        end
        finish_message();
      end
    end
  endtask

  initial begin
    rst_ni       <= 1'b0;
    cfg_we_i     <= 1'b0;
    cfg_wdata_i  <= 1'b0;
    in_valid_i   <= 1'b0;
    opcode_i     <= smp_pkg::OpAppend;
    data_byte_i  <= 8'h00;
    out_stall_i  <= 1'b0;
    mismatch_count = 0;
    items_sent     = 0;
    in_gaps_on     = 1'b1;
    out_gaps_on    = 1'b1;
    hold_request   = 0;
    hold_left      = 0;
    stall_left     = 0;
    msg_len        = '0;
    tail_bytes     = '0;
    mode_384       = ModeSha256;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_messages();
    test_word_packing();
    test_mode_switch_mid_message();
    test_backpressure();
    test_random_messages();
    wait_drained();

    if (mismatch_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

FILE: sha2_message_padder.f
+incdir+rtl
rtl/smp_pkg.sv
rtl/smp_accum.sv
rtl/smp_pad_seq.sv
rtl/sha2_message_padder.sv
tb/tb.sv
